[src/fzk_pkg.sv]
// Shared types and constants of the FEN Zobrist key block.
// Used by the front parser, the operation queue, the back end and the top level.
package fzk_pkg;

  localparam int unsigned TABLE_WORDS = 781;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned KEY_W       = 64;

  localparam logic [ADDR_W-1:0] CASTLE_BASE = 10'd768;
  localparam logic [ADDR_W-1:0] EP_BASE     = 10'd772;
  localparam logic [ADDR_W-1:0] SIDE_WORD   = 10'd780;

  // One operation handed from the parser to the back end.
  typedef struct packed {
    logic              is_write;
    logic              xor_en;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  wdata;
    logic              last;
    logic              ep_en;
    logic [ADDR_W-1:0] ep_addr;
    logic              side_en;
  } fzk_op_t;

endpackage

[src/fzk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fzk_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 781
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/fzk_front.sv]
// Front end: accepts input items, parses the position text and emits table operations.
// Depends on fzk_pkg.
module fzk_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic                    cmd,
  input  logic [7:0]              fen_char,
  input  logic                    last_char,
  input  logic [9:0]              table_index,
  input  logic [63:0]             table_value,
  output logic                    push,
  output fzk_pkg::fzk_op_t        op
);

  logic [2:0] field_number, field_number_next;
  logic       in_gap, in_gap_next;
  logic [4:0] board_row, board_row_next;
  logic [6:0] board_col, board_col_next;
  logic [3:0] castle_seen, castle_seen_next;
  logic [7:0] colour_first, colour_first_next;
  logic [1:0] colour_length, colour_length_next;
  logic [7:0] ep_first, ep_first_next;
  logic [1:0] ep_length, ep_length_next;
  logic [7:0] white_pawns_rank5, white_pawns_rank5_next;
  logic [7:0] black_pawns_rank4, black_pawns_rank4_next;

  function automatic logic [4:0] piece_code(input logic [7:0] c);
    case (c)
      "p":     piece_code = 5'd0;
      "P":     piece_code = 5'd1;
      "n":     piece_code = 5'd2;
      "N":     piece_code = 5'd3;
      "b":     piece_code = 5'd4;
      "B":     piece_code = 5'd5;
      "r":     piece_code = 5'd6;
      "R":     piece_code = 5'd7;
      "q":     piece_code = 5'd8;
      "Q":     piece_code = 5'd9;
      "k":     piece_code = 5'd10;
      "K":     piece_code = 5'd11;
      default: piece_code = 5'h10;
    endcase
  endfunction

  function automatic logic [6:0] col_add(input logic [6:0] col, input logic [3:0] n);
    logic [7:0] sum;
    sum = {1'b0, col} + {4'd0, n};
    col_add = sum[7] ? 7'd127 : sum[6:0];
  endfunction

  always_comb begin
    logic [4:0] piece;
    logic [1:0] cbit;
    logic       cvalid;
    logic       white;
    logic       black;
    logic [2:0] file;
    logic [7:0] onehot;
    logic [7:0] adj;
    logic [7:0] mask;

    field_number_next      = field_number;
    in_gap_next            = in_gap;
    board_row_next         = board_row;
    board_col_next         = board_col;
    castle_seen_next       = castle_seen;
    colour_first_next      = colour_first;
    colour_length_next     = colour_length;
    ep_first_next          = ep_first;
    ep_length_next         = ep_length;
    white_pawns_rank5_next = white_pawns_rank5;
    black_pawns_rank4_next = black_pawns_rank4;
    piece  = piece_code(fen_char);
    cbit   = 2'd0;
    cvalid = 1'b0;
    white  = 1'b0;
    black  = 1'b0;
    file   = 3'd0;
    onehot = 8'd0;
    adj    = 8'd0;
    mask   = 8'd0;

    op          = '0;
    op.addr     = table_index;
    op.wdata    = table_value;
    push        = 1'b0;

    if (cmd) begin
      op.is_write = 1'b1;
      push = accept && (table_index < 10'(fzk_pkg::TABLE_WORDS));
    end else begin
      if (fen_char inside {8'd32, [8'd9:8'd13]}) begin
        if (!in_gap) begin
          if (field_number < 3'd4) begin
            field_number_next = field_number + 3'd1;
          end
          in_gap_next = 1'b1;
        end
      end else begin
        in_gap_next = 1'b0;
        case (field_number)
          3'd0: begin
            if (fen_char == "/") begin
              board_row_next = (board_row inside {[5'd1:5'd7]}) ? board_row - 5'd1 : 5'd31;
              board_col_next = 7'd0;
            end else if (fen_char inside {[8'h30:8'h39]}) begin
              board_col_next = col_add(board_col, fen_char[3:0]);
            end else begin
              if (!piece[4] && board_row <= 5'd7 && board_col <= 7'd7) begin
                op.xor_en = 1'b1;
                op.addr   = {piece[3:0], board_row[2:0], board_col[2:0]};
                if (piece == 5'd1 && board_row == 5'd4) begin
                  white_pawns_rank5_next = white_pawns_rank5 | (8'd1 << board_col[2:0]);
                end
                if (piece == 5'd0 && board_row == 5'd3) begin
                  black_pawns_rank4_next = black_pawns_rank4 | (8'd1 << board_col[2:0]);
                end
              end
              board_col_next = col_add(board_col, 4'd1);
            end
          end
          3'd1: begin
            if (colour_length == 2'd0) begin
              colour_first_next = fen_char;
            end
            if (colour_length < 2'd3) begin
              colour_length_next = colour_length + 2'd1;
            end
          end
          3'd2: begin
            case (fen_char)
              "K": begin cbit = 2'd0; cvalid = 1'b1; end
              "Q": begin cbit = 2'd1; cvalid = 1'b1; end
              "k": begin cbit = 2'd2; cvalid = 1'b1; end
              "q": begin cbit = 2'd3; cvalid = 1'b1; end
              default: cvalid = 1'b0;
            endcase
            if (cvalid && !castle_seen[cbit]) begin
              castle_seen_next[cbit] = 1'b1;
              op.xor_en = 1'b1;
              op.addr   = fzk_pkg::CASTLE_BASE + {8'd0, cbit};
            end
          end
          3'd3: begin
            if (ep_length == 2'd0) begin
              ep_first_next = fen_char;
            end
            if (ep_length < 2'd3) begin
              ep_length_next = ep_length + 2'd1;
            end
          end
          default: ;
        endcase
      end

      // Closing words are decided from the state as it stands after this character.
      white  = (colour_length_next == 2'd1) && (colour_first_next == "w");
      black  = (colour_length_next == 2'd1) && (colour_first_next == "b");
      file   = 3'(ep_first_next - 8'h61);
      onehot = 8'd1 << file;
      adj    = (onehot >> 1) | (onehot << 1);
      mask   = white ? white_pawns_rank5_next : (black ? black_pawns_rank4_next : 8'd0);
      op.last    = last_char;
      op.side_en = white;
      op.ep_en   = (ep_length_next != 2'd0) && (ep_first_next inside {[8'h61:8'h68]})
                   && ((mask & adj) != 8'd0);
      op.ep_addr = fzk_pkg::EP_BASE + {7'd0, file};
      push = accept && (op.xor_en || last_char);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && !cmd && last_char)) begin
      field_number      <= 3'd0;
      in_gap            <= 1'b1;
      board_row         <= 5'd7;
      board_col         <= 7'd0;
      castle_seen       <= 4'd0;
      colour_first      <= 8'd0;
      colour_length     <= 2'd0;
      ep_first          <= 8'd0;
      ep_length         <= 2'd0;
      white_pawns_rank5 <= 8'd0;
      black_pawns_rank4 <= 8'd0;
    end else if (accept && !cmd) begin
      field_number      <= field_number_next;
      in_gap            <= in_gap_next;
      board_row         <= board_row_next;
      board_col         <= board_col_next;
      castle_seen       <= castle_seen_next;
      colour_first      <= colour_first_next;
      colour_length     <= colour_length_next;
      ep_first          <= ep_first_next;
      ep_length         <= ep_length_next;
      white_pawns_rank5 <= white_pawns_rank5_next;
      black_pawns_rank4 <= black_pawns_rank4_next;
    end
  end

endmodule

[src/fzk_queue.sv]
// Short FIFO of parsed operations between the front end and the back end.
// Depends on fzk_pkg.
module fzk_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fzk_pkg::fzk_op_t push_op,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output fzk_pkg::fzk_op_t head_op
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fzk_pkg::fzk_op_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("operation queue written while full");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("operation queue count out of range");

endmodule

[src/fzk_back.sv]
// Back end: executes queued operations against the random table and builds the key.
// Depends on fzk_pkg and fzk_ram.
module fzk_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  fzk_pkg::fzk_op_t head_op,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [63:0]      position_key
);

  logic        ram_we;
  logic        ram_re;
  logic [9:0]  ram_raddr;
  logic [63:0] ram_rdata;

  logic        done_char, done_ep;
  logic        done_char_next, done_ep_next;
  logic        tok_valid, tok_xor, tok_final;
  logic        s1_valid, s1_xor, s1_final;
  logic [63:0] acc;
  logic [63:0] acc_value;
  logic        slot_free;

  fzk_ram #(
    .WIDTH(fzk_pkg::KEY_W),
    .DEPTH(fzk_pkg::TABLE_WORDS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(head_op.addr),
    .wdata(head_op.wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The result register must be empty by the time a closing token reaches it.
  assign slot_free = (!out_valid || out_ready) && !(s1_valid && s1_final);

  always_comb begin
    logic pc;
    logic pe;
    logic ps;
    logic fin;

    pc = head_op.xor_en && !done_char;
    pe = head_op.last && head_op.ep_en && !done_ep;
    ps = head_op.last && head_op.side_en;
    fin = 1'b1;

    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = head_op.addr;
    tok_valid      = 1'b0;
    tok_xor        = 1'b0;
    tok_final      = 1'b0;
    done_char_next = done_char;
    done_ep_next   = done_ep;

    if (head_valid) begin
      if (head_op.is_write) begin
        ram_we = 1'b1;
        pop    = 1'b1;
      end else if (!head_op.last) begin
        ram_re    = head_op.xor_en;
        tok_valid = head_op.xor_en;
        tok_xor   = head_op.xor_en;
        pop       = 1'b1;
      end else begin
        if (pc) begin
          ram_raddr = head_op.addr;
          fin       = !(pe || ps);
        end else if (pe) begin
          ram_raddr = head_op.ep_addr;
          fin       = !ps;
        end else begin
          ram_raddr = fzk_pkg::SIDE_WORD;
          fin       = 1'b1;
        end
        if (!fin || slot_free) begin
          ram_re    = pc || pe || ps;
          tok_valid = 1'b1;
          tok_xor   = pc || pe || ps;
          tok_final = fin;
          if (fin) begin
            pop            = 1'b1;
            done_char_next = 1'b0;
            done_ep_next   = 1'b0;
          end else if (pc) begin
            done_char_next = 1'b1;
          end else begin
            done_ep_next = 1'b1;
          end
        end
      end
    end
  end

  assign acc_value = acc ^ (s1_xor ? ram_rdata : 64'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done_char <= 1'b0;
      done_ep   <= 1'b0;
      s1_valid  <= 1'b0;
      s1_xor    <= 1'b0;
      s1_final  <= 1'b0;
      acc       <= 64'd0;
      out_valid <= 1'b0;
    end else begin
      done_char <= done_char_next;
      done_ep   <= done_ep_next;
      s1_valid  <= tok_valid;
      s1_xor    <= tok_xor;
      s1_final  <= tok_final;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_valid) begin
        if (s1_final) begin
          acc       <= 64'd0;
          out_valid <= 1'b1;
        end else begin
          acc <= acc_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_final) begin
      position_key <= acc_value;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_final) |-> (!out_valid || out_ready))
    else $error("closing token would overwrite an untaken result");
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst) !(ram_we && ram_re))
    else $error("table written and read in the same cycle");
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_final) |=> (acc == 64'd0))
    else $error("running key not cleared after a result");

endmodule

[src/fen_zobrist_key_top.sv]
// Top level of the FEN Zobrist key block.
// Depends on fzk_pkg, fzk_front, fzk_queue and fzk_back (which holds fzk_ram).
//
// Usage: the input channel carries one item per transfer. With cmd high the item writes
// table_value into the 781-word random table at table_index (indexes above 780 are
// dropped). With cmd low it carries one character of a position text; the item that
// has last_char high closes the text, and one transfer on the output channel follows
// with the finished 64-bit key in position_key. Load the table before any text.
//
// Throughput: one input item per cycle while the queue has space. The parser classifies
// each character in the cycle of its transfer and queues at most one table operation,
// and the back end does one table access per cycle, never a write and a read together,
// except while a closing item waits for the output slot. A closing character may read
// its own word, the en-passant word and the side word in turn, so the queue absorbs
// that burst.
// The key follows the closing transfer once the operations ahead of it in the queue
// have been executed.
// Reset clears the parser, the queue, the running key and the output valid flag; the
// table keeps its contents. A stalled receiver holds the key in the output register,
// and input is accepted until the queue fills behind it.
module fen_zobrist_key_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  fen_char,
  input  logic        last_char,
  input  logic [9:0]  table_index,
  input  logic [63:0] table_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] position_key
);

  logic             accept;
  logic             push;
  logic             full;
  logic             pop;
  logic             head_valid;
  fzk_pkg::fzk_op_t push_op;
  fzk_pkg::fzk_op_t head_op;

  // Every accepted item queues at most one operation, so space in the queue is all
  // the input side needs.
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  fzk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd),
    .fen_char   (fen_char),
    .last_char  (last_char),
    .table_index(table_index),
    .table_value(table_value),
    .push       (push),
    .op         (push_op)
  );

  fzk_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_op   (head_op)
  );

  fzk_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_op     (head_op),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .position_key(position_key)
  );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for fen_zobrist_key_top: loads the random table, streams position texts one
// character per transfer and checks every finished key against its own predictor or a typed key.
// Depends on fzk_pkg and the block's RTL; it needs no other file.
module tb_top;

  // Item kinds carried on the cmd field.
  localparam logic CMD_TEXT  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Generous bound on the whole run.
  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_ROWS    = 22;

  // Piece codes select the 64-word slice of the table for that piece.
  typedef enum int {
    PC_NONE = -1, PC_BPAWN, PC_WPAWN, PC_BKNIGHT, PC_WKNIGHT, PC_BBISHOP, PC_WBISHOP,
    PC_BROOK, PC_WROOK, PC_BQUEEN, PC_WQUEEN, PC_BKING, PC_WKING
  } piece_e;

  // Fields of the position text, in the order they arrive.
  typedef enum logic [2:0] {FLD_PLACE, FLD_SIDE, FLD_CASTLE, FLD_EP, FLD_REST} field_e;

  // Castling rights, each owning one word from CASTLE_BASE up.
  typedef enum int {CR_WKING, CR_WQUEEN, CR_BKING, CR_BQUEEN} castle_e;

  // One row of the directed stimulus. Where typed is set, key is the expected result.
  typedef struct packed {
    logic        c;
    logic [7:0]  ch;
    logic        lst;
    logic [9:0]  ix;
    logic [63:0] v;
    logic        typed;
    logic [63:0] key;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        cmd;
  logic [7:0]  fen_char;
  logic        last_char;
  logic [9:0]  table_index;
  logic [63:0] table_value;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] position_key;

  fen_zobrist_key_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .fen_char     (fen_char),
    .last_char    (last_char),
    .table_index  (table_index),
    .table_value  (table_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .position_key (position_key)
  );

  // Shadow copy of the block's table and parse state.
  logic [63:0] zob_tab [0:780];
  logic [63:0] acc_key;
  field_e      fld;
  logic        gap;
  logic [4:0]  row_pos;
  logic [6:0]  col_pos;
  logic [3:0]  castle_done;
  logic [7:0]  side_ch;
  logic [1:0]  side_len;
  logic [7:0]  ep_ch;
  logic [1:0]  ep_len;
  logic [7:0]  wp_rank5;
  logic [7:0]  bp_rank4;

  // Keys predicted for closing transfers, oldest first.
  logic [63:0] pending_keys [$];
  logic [7:0]  fen_q [$];
  logic [63:0] got_want;
  int          mismatches = 0;
  bit          calm;

  logic [7:0] piece_chars [12] = '{"p", "P", "n", "N", "b", "B", "r", "R", "q", "Q", "k", "K"};
  logic [7:0] ws_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  logic [7:0] castle_chars [4] = '{"K", "Q", "k", "q"};

  stim_row_t dir_rows [DIR_ROWS];

  // The clock runs free; period 10 ns.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both sides idle at random, with odds of 16 in a hundred, except inside the calm stretch.
  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 16);
  endfunction

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic stim_row_t mk(logic c, logic [7:0] ch, logic lst, logic [9:0] ix,
                                   logic [63:0] v, logic typed, logic [63:0] key);
    stim_row_t r;
    r = '{c, ch, lst, ix, v, typed, key};
    return r;
  endfunction

  // Appends one character to the text being built.
  task automatic put_char(logic [7:0] ch);
    fen_q = {fen_q, ch};
  endtask

  // ---------------------------------------------------------------------------
  // Predictor of the key computation.
  // ---------------------------------------------------------------------------

  task automatic restart_text();
    acc_key     = '0;
    fld         = FLD_PLACE;
    gap         = 1'b1;
    row_pos     = 5'd7;
    col_pos     = 7'd0;
    castle_done = '0;
    side_ch     = '0;
    side_len    = '0;
    ep_ch       = '0;
    ep_len      = '0;
    wp_rank5    = '0;
    bp_rank4    = '0;
  endtask

  function automatic piece_e piece_of(logic [7:0] ch);
    case (ch)
      "p": return PC_BPAWN;
      "P": return PC_WPAWN;
      "n": return PC_BKNIGHT;
      "N": return PC_WKNIGHT;
      "b": return PC_BBISHOP;
      "B": return PC_WBISHOP;
      "r": return PC_BROOK;
      "R": return PC_WROOK;
      "q": return PC_BQUEEN;
      "Q": return PC_WQUEEN;
      "k": return PC_BKING;
      "K": return PC_WKING;
      default: return PC_NONE;
    endcase
  endfunction

  // Columns saturate at 127 so that long runs stay off the board.
  task automatic step_col(int n);
    int t;
    t = int'(col_pos) + n;
    col_pos = (t > 127) ? 7'd127 : t[6:0];
  endtask

  task automatic place_char(logic [7:0] ch);
    piece_e pc;
    int     ix;
    if (ch == "/") begin
      // Stepping below the first rank parks the row off the board for good.
      if (row_pos >= 5'd1 && row_pos <= 5'd7) row_pos = row_pos - 5'd1;
      else row_pos = 5'd31;
      col_pos = 7'd0;
    end else if (ch >= "0" && ch <= "9") begin
      step_col(int'(ch - "0"));
    end else begin
      pc = piece_of(ch);
      if (pc != PC_NONE && row_pos <= 5'd7 && col_pos <= 7'd7) begin
        ix = 64 * int'(pc) + 8 * int'(row_pos) + int'(col_pos);
        acc_key = acc_key ^ zob_tab[ix];
        if (pc == PC_WPAWN && row_pos == 5'd4) wp_rank5[col_pos[2:0]] = 1'b1;
        if (pc == PC_BPAWN && row_pos == 5'd3) bp_rank4[col_pos[2:0]] = 1'b1;
      end
      step_col(1);
    end
  endtask

  task automatic castle_char(logic [7:0] ch);
    castle_e b;
    case (ch)
      "K": b = CR_WKING;
      "Q": b = CR_WQUEEN;
      "k": b = CR_BKING;
      "q": b = CR_BQUEEN;
      default: return;
    endcase
    // Repeated letters count once.
    if (!castle_done[int'(b)]) begin
      castle_done[int'(b)] = 1'b1;
      acc_key = acc_key ^ zob_tab[int'(fzk_pkg::CASTLE_BASE) + int'(b)];
    end
  endtask

  function automatic logic [63:0] closing_key();
    logic [63:0] k;
    logic [7:0]  mask;
    logic [7:0]  adj;
    bit          white;
    bit          black;
    int          f;
    k     = acc_key;
    white = side_len == 2'd1 && side_ch == "w";
    black = side_len == 2'd1 && side_ch == "b";
    // The en-passant word counts only when a pawn of the side to move can capture.
    if (ep_len >= 2'd1 && ep_ch >= "a" && ep_ch <= "h") begin
      f    = int'(ep_ch - "a");
      mask = white ? wp_rank5 : (black ? bp_rank4 : 8'd0);
      adj  = '0;
      if (f > 0) adj[f-1] = 1'b1;
      if (f < 7) adj[f+1] = 1'b1;
      if ((mask & adj) != 8'd0) k = k ^ zob_tab[int'(fzk_pkg::EP_BASE) + f];
    end
    if (white) k = k ^ zob_tab[int'(fzk_pkg::SIDE_WORD)];
    return k;
  endfunction

  // Applies one accepted item to the shadow state; a closing character queues its key.
  task automatic follow_item(logic c, logic [7:0] ch, logic lst, logic [9:0] ix,
                             logic [63:0] v, logic typed, logic [63:0] typed_key);
    logic [63:0] k;
    if (c == CMD_WRITE) begin
      if (ix < fzk_pkg::TABLE_WORDS) zob_tab[ix] = v;
      return;
    end
    if (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D)) begin
      if (!gap) begin
        if (fld != FLD_REST) fld = field_e'(fld + 3'd1);
        gap = 1'b1;
      end
    end else begin
      gap = 1'b0;
      case (fld)
        FLD_PLACE:  place_char(ch);
        FLD_SIDE: begin
          if (side_len == 2'd0) side_ch = ch;
          if (side_len < 2'd3) side_len = side_len + 2'd1;
        end
        FLD_CASTLE: castle_char(ch);
        FLD_EP: begin
          if (ep_len == 2'd0) ep_ch = ch;
          if (ep_len < 2'd3) ep_len = ep_len + 2'd1;
        end
        default: ;
      endcase
    end
    if (lst) begin
      k = typed ? typed_key : closing_key();
      pending_keys = {pending_keys, k};
      restart_text();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Every call starts at a falling edge and returns at the falling edge
  // after its transfer, leaving valid high so back-to-back items need no toggle.
  // ---------------------------------------------------------------------------
  task automatic push_item(logic c, logic [7:0] ch, logic lst, logic [9:0] ix,
                           logic [63:0] v, logic typed, logic [63:0] typed_key);
    while (idle_now()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    cmd         = c;
    fen_char    = ch;
    last_char   = lst;
    table_index = ix;
    table_value = v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    follow_item(c, ch, lst, ix, v, typed, typed_key);
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted key has been delivered.
  task automatic drain_keys();
    in_valid = 1'b0;
    while (pending_keys.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Text generator. Most texts are well formed with random content; pawns are common
  // on the capture ranks so that the en-passant rule fires. A share of texts is noise.
  // ---------------------------------------------------------------------------
  task automatic add_ws();
    put_char(($urandom_range(99) < 70) ? 8'h20 : ws_chars[$urandom_range(5)]);
    if ($urandom_range(99) < 20) put_char(ws_chars[$urandom_range(5)]);
  endtask

  task automatic gen_rank(int row);
    int col;
    int r;
    int n;
    bit pawny;
    logic [7:0] ch;
    col   = 0;
    pawny = (row == 3 || row == 4);
    while (col < 8) begin
      r = $urandom_range(99);
      if (r < 28) begin
        n = $urandom_range(8 - col, 1);
        put_char(8'("0" + n));
        col += n;
      end else if (r < 32) begin
        // A zero skip or an oversized one; the latter pushes later pieces off the board.
        put_char($urandom_range(1) ? "9" : "0");
        col++;
      end else if (r < 36) begin
        ch = 8'($urandom_range(126, 33));
        put_char((ch == "/") ? "x" : ch);
        col++;
      end else if (r < 40) begin
        break;
      end else begin
        if (pawny && $urandom_range(99) < 60) begin
          if (row == 4) put_char(($urandom_range(99) < 70) ? "P" : "p");
          else put_char(($urandom_range(99) < 70) ? "p" : "P");
        end else begin
          put_char(piece_chars[$urandom_range(11)]);
        end
        col++;
      end
    end
    if ($urandom_range(99) < 5) put_char(piece_chars[$urandom_range(11)]);
  endtask

  task automatic gen_text();
    int r;
    int n;
    int depth;
    fen_q.delete();
    if ($urandom_range(99) < 10) begin
      n = $urandom_range(12, 1);
      repeat (n) put_char(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(99) < 25) add_ws();
      r = $urandom_range(99);
      if (r < 50) n = $urandom_range(5, 4);
      else if (r < 80) n = $urandom_range(3, 1);
      else if (r < 92) n = 8;
      else n = $urandom_range(12, 9);
      for (int i = 0; i < n; i++) begin
        if (i > 0) put_char("/");
        if ((7 - i == 3) || (7 - i == 4) || $urandom_range(99) < 40) gen_rank(7 - i);
      end
      // A few texts stop early, after the placement, colour or castling field.
      depth = ($urandom_range(99) < 12) ? $urandom_range(3, 1) : 4;
      if (depth > 1) begin
        add_ws();
        r = $urandom_range(99);
        if (r < 45) put_char("w");
        else if (r < 85) put_char("b");
        else if (r < 90) put_char("W");
        else if (r < 95) begin
          put_char("w");
          put_char("w");
        end else begin
          put_char("b");
          put_char("w");
        end
      end
      if (depth > 2) begin
        add_ws();
        if ($urandom_range(99) < 25) begin
          put_char("-");
        end else begin
          n = fen_q.size();
          for (int i = 0; i < 4; i++)
            if ($urandom_range(99) < 60) put_char(castle_chars[i]);
          if (fen_q.size() == n) put_char("-");
          if ($urandom_range(99) < 15) put_char(castle_chars[$urandom_range(3)]);
          if ($urandom_range(99) < 10) put_char("x");
        end
      end
      if (depth > 3) begin
        add_ws();
        r = $urandom_range(99);
        if (r < 35) begin
          put_char("-");
        end else if (r < 90) begin
          put_char(8'("a" + $urandom_range(7)));
          if ($urandom_range(99) < 70) put_char($urandom_range(1) ? "3" : "6");
        end else begin
          r = $urandom_range(3);
          put_char((r == 0) ? 8'h60 : (r == 1) ? "i" : (r == 2) ? "A" : "@");
        end
        if ($urandom_range(99) < 40) begin
          add_ws();
          put_char("0");
          add_ws();
          put_char("1");
          if ($urandom_range(99) < 25) begin
            add_ws();
            put_char("h");
          end
        end
      end
      if ($urandom_range(99) < 15) add_ws();
    end
    if (fen_q.size() == 0) put_char(8'h20);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: the receiver stalls at random and every transfer is checked.
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = !idle_now();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_keys.size() == 0) begin
        $display("%0t: key with none expected: expected none, actual %h",
                 $time, position_key);
        mismatches++;
      end else begin
        got_want = pending_keys.pop_front();
        if (position_key !== got_want) begin
          $display("%0t: position_key mismatch: expected %h, actual %h",
                   $time, got_want, position_key);
          mismatches++;
        end
      end
    end
  end

  // A hung block ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** fen_zobrist_key_top: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int  rnd_items;
    int  closes;
    bit  paused_mid;
    bit  keys_lost;
    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = CMD_TEXT;
    fen_char    = '0;
    last_char   = 1'b0;
    table_index = '0;
    table_value = '0;
    calm        = 1'b0;
    rnd_items   = 0;
    closes      = 0;
    paused_mid  = 1'b0;
    keys_lost   = 1'b0;
    for (int i = 0; i < 781; i++) zob_tab[i] = '0;
    restart_text();

    // Directed rows. Known words go to the white king on a8 and to the side word so
    // that the first keys can be typed in; the en-passant text is left to the predictor.
    dir_rows = '{
      mk(CMD_WRITE, 8'h00, 1'b0, 10'h3FF, 64'h0,                  1'b0, 64'h0),
      mk(CMD_WRITE, 8'hFF, 1'b1, 10'd781, '1,                     1'b0, 64'h0),
      mk(CMD_WRITE, 8'h00, 1'b0, 10'd760, '1,                     1'b0, 64'h0),
      mk(CMD_WRITE, 8'h00, 1'b0, 10'd780, 64'h8000_0000_0000_0001, 1'b0, 64'h0),
      mk(CMD_TEXT,  "K",   1'b1, 10'd0,   64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF),
      mk(CMD_TEXT,  8'h20, 1'b1, 10'd0,   64'h0, 1'b1, 64'h0),
      mk(CMD_TEXT,  "K",   1'b0, 10'd0,   64'h0, 1'b0, 64'h0),
      mk(CMD_TEXT,  8'h20, 1'b0, 10'd0,   64'h0, 1'b0, 64'h0),
      mk(CMD_TEXT,  "w",   1'b1, 10'd0,   64'h0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE),
      mk(CMD_TEXT,  8'hFF, 1'b1, 10'h3FF, '1,    1'b1, 64'h0),
      mk(CMD_TEXT,  8'h00, 1'b1, 10'd0,   64'h0, 1'b1, 64'h0),
      mk(CMD_TEXT,  "/",   1'b0, 10'd0,   64'h0, 1'b0, 64'h0),
      mk(CMD_TEXT,  "/",   1'b0, 10'd0,   64'h0, 1'b0, 64'h0),
      mk(CMD_TEXT,  "/",   1'b0, 10'd0,   64'h0, 1'b0, 64'h0),
      mk(CMD_TEXT,  "3",   1'b0, 10'd0,   64'h0, 1'b0, 64'h0),
      mk(CMD_TEXT,  "P",   1'b0, 10'd0,   64'h0, 1'b0, 64'h0),
      mk(CMD_TEXT,  8'h20, 1'b0, 10'd0,   64'h0, 1'b0, 64'h0),
      mk(CMD_TEXT,  "w",   1'b0, 10'd0,   64'h0, 1'b0, 64'h0),
      mk(CMD_TEXT,  8'h09, 1'b0, 10'd0,   64'h0, 1'b0, 64'h0),
      mk(CMD_TEXT,  "-",   1'b0, 10'd0,   64'h0, 1'b0, 64'h0),
      mk(CMD_TEXT,  8'h20, 1'b0, 10'd0,   64'h0, 1'b0, 64'h0),
      mk(CMD_TEXT,  "e",   1'b1, 10'd0,   64'h0, 1'b0, 64'h0)
    };

    // Reset is released at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the whole table first so no text ever reads an unwritten word.
    for (int i = 0; i < 781; i++)
      push_item(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), 10'(i),
                rand_word(), 1'b0, 64'h0);

    for (int i = 0; i < DIR_ROWS; i++)
      push_item(dir_rows[i].c, dir_rows[i].ch, dir_rows[i].lst, dir_rows[i].ix,
                dir_rows[i].v, dir_rows[i].typed, dir_rows[i].key);
    drain_keys();
    @(negedge clk);

    // Random texts, with table rewrites slipped in between characters.
    while (rnd_items < 1050 || closes < 24) begin
      calm = (rnd_items >= 200 && rnd_items < 450);
      if (!paused_mid && rnd_items >= 600) begin
        paused_mid = 1'b1;
        drain_keys();
        @(negedge clk);
      end
      gen_text();
      for (int i = 0; i < fen_q.size(); i++) begin
        if ($urandom_range(99) < 5) begin
          push_item(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    10'($urandom_range(1023)), rand_word(), 1'b0, 64'h0);
          rnd_items++;
        end
        push_item(CMD_TEXT, fen_q[i], i == fen_q.size() - 1, 10'($urandom_range(1023)),
                  rand_word(), 1'b0, 64'h0);
        rnd_items++;
      end
      closes++;
    end
    calm = 1'b0;

    // Wait for the last keys, then give the block time to show any stray transfer.
    drain_keys();
    repeat (20) @(negedge clk);
    if (pending_keys.size() != 0) begin
      $display("%0t: keys never delivered: expected %0d more, actual 0",
               $time, pending_keys.size());
      keys_lost = 1'b1;
    end
    if (mismatches == 0 && !keys_lost) begin
      $display("** fen_zobrist_key_top: PASSED **");
    end else begin
      $display("** fen_zobrist_key_top: FAILED **");
    end
    $finish;
  end

endmodule

[fen_zobrist_key_top.f]
src/fzk_pkg.sv
src/fzk_ram.sv
src/fzk_front.sv
src/fzk_queue.sv
src/fzk_back.sv
src/fen_zobrist_key_top.sv
sim/tb_top.sv
